// File: rtl/core/arll_pkg.sv
// ----------------------------------------------------------------------------
// arll_pkg
// Shared types and constants of the array linked list manager.
// ----------------------------------------------------------------------------
package arll_pkg;

  localparam int DEF_CAPACITY = 128;

  localparam int ACTION_W = 3;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 8;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  localparam logic [ACTION_W-1:0] ACT_APPEND   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DEL_KEY  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FIND     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DEL_POS  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_READ     = 3'd5;

  localparam logic [STATUS_W-1:0] STS_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] STS_BEYOND   = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STS_BADPOS   = 3'd4;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_GET,
    S_WALK,
    S_WALK_GET,
    S_LINK_RD,
    S_LINK_GET,
    S_INS_W1,
    S_INS_W2,
    S_DP_RD,
    S_DP_GET,
    S_DP_NXT_RD,
    S_DP_NXT_GET,
    S_DP_W1,
    S_DP_W2,
    S_RD_RD,
    S_RD_GET,
    S_FD_RD,
    S_FD_GET,
    S_DK_RD,
    S_DK_GET,
    S_DK_W1,
    S_DK_W2,
    S_RESULT
  } arll_state_t;

endpackage

// File: rtl/core/array_linked_list_manager.sv
// ----------------------------------------------------------------------------
// array_linked_list_manager
// Singly linked list kept in a slot memory with a free list through the
// unused slots.
//
// Each input transaction carries an action in in_tuser and a key, a handle
// and a 1-based position in in_tdata. Every request returns exactly one
// output transaction with the status in out_tuser and the found key, found
// handle, list length and empty and full flags in out_tdata.
// The links, keys and handles live in two memories: a link memory and a
// key and handle memory, both with a registered read. Each step along the
// chain is a read issue followed by a read return, so find, append and the
// positional requests walk the chain node by node. Delete by key unlinks
// every matching node and returns each one to the free list.
// The block takes one request at a time. A new request is accepted while the
// previous result still waits in the output register; a stalled receiver
// holds the next result in its final state.
// After reset the link memory is initialized in one pass over all CAPACITY
// slots, during which no request is accepted. The list then starts empty.
// ----------------------------------------------------------------------------
module array_linked_list_manager
  import arll_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // action
  input  logic [ACTION_W-1:0]   in_tuser,
  // element_key, element_handle, position
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status
  output logic [STATUS_W-1:0]   out_tuser,
  // found_key, found_handle, list_length, is_empty, is_full, zero padding
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int CW = SW;
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [SW-1:0] NIL = SW'(CAPACITY);
  localparam logic [CW-1:0] CNT_MAX = CW'(CAPACITY);
  localparam logic [AW-1:0] CLR_LAST = AW'(CAPACITY - 1);
  localparam int DW = KEY_W + HANDLE_W;

  arll_state_t state_r, state_nxt;

  logic [ACTION_W-1:0] act_r, act_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [SW-1:0]       head_r, head_nxt;
  logic [SW-1:0]       free_r, free_nxt;
  logic [SW-1:0]       cur_r, cur_nxt;
  logic [SW-1:0]       prev_r, prev_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic [SW-1:0]       link_r, link_nxt;
  logic                prev_nil_r, prev_nil_nxt;
  logic                hit_r, hit_nxt;
  logic [XW-1:0]       steps_r, steps_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [KEY_W-1:0]    fkey_r, fkey_nxt;
  logic [HANDLE_W-1:0] fhandle_r, fhandle_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [KEY_W-1:0]    out_key_r, out_key_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic                out_full_r, out_full_nxt;

  logic          l_we;
  logic [AW-1:0] l_waddr, l_raddr;
  logic [SW-1:0] l_wdata, l_rdata;
  logic          d_we;
  logic [AW-1:0] d_waddr, d_raddr;
  logic [DW-1:0] d_wdata, d_rdata;

  logic [KEY_W-1:0]    in_key;
  logic [HANDLE_W-1:0] in_handle;
  logic [POS_W-1:0]    in_pos;
  logic [XW-1:0]       pos_x, cnt_x;

  assign in_key    = in_tdata[31:0];
  assign in_handle = in_tdata[63:32];
  assign in_pos    = in_tdata[71:64];
  assign pos_x     = XW'(in_pos);
  assign cnt_x     = XW'(cnt_r);

  arll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  arll_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      head_r      <= NIL;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    handle_r     <= handle_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    slot_r       <= slot_nxt;
    link_r       <= link_nxt;
    prev_nil_r   <= prev_nil_nxt;
    hit_r        <= hit_nxt;
    steps_r      <= steps_nxt;
    status_r     <= status_nxt;
    fkey_r       <= fkey_nxt;
    fhandle_r    <= fhandle_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_handle_r <= out_handle_nxt;
    out_len_r    <= out_len_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    handle_nxt     = handle_r;
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    free_nxt       = free_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    slot_nxt       = slot_r;
    link_nxt       = link_r;
    prev_nil_nxt   = prev_nil_r;
    hit_nxt        = hit_r;
    steps_nxt      = steps_r;
    status_nxt     = status_r;
    fkey_nxt       = fkey_r;
    fhandle_nxt    = fhandle_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_handle_nxt = out_handle_r;
    out_len_nxt    = out_len_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;
    in_tready      = 1'b0;
    l_we           = 1'b0;
    l_waddr        = cur_r[AW-1:0];
    l_wdata        = slot_r;
    l_raddr        = cur_r[AW-1:0];
    d_we           = 1'b0;
    d_waddr        = slot_r[AW-1:0];
    d_wdata        = {handle_r, key_r};
    d_raddr        = cur_r[AW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        l_we    = 1'b1;
        l_waddr = clr_r;
        l_wdata = SW'(clr_r) + SW'(1);
        clr_nxt = clr_r + AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          act_nxt     = in_tuser;
          key_nxt     = in_key;
          handle_nxt  = in_handle;
          fkey_nxt    = '0;
          fhandle_nxt = '0;
          status_nxt  = STS_DONE;
          cur_nxt     = head_r;
          prev_nxt    = NIL;
          hit_nxt     = 1'b0;
          state_nxt   = S_RESULT;
          case (in_tuser)
            ACT_APPEND: begin
              prev_nil_nxt = (cnt_r == '0);
              steps_nxt    = cnt_x - XW'(1);
              if (cnt_r >= CNT_MAX || free_r == NIL) begin
                status_nxt = STS_FULL;
              end else begin
                state_nxt = S_ALLOC_RD;
              end
            end
            ACT_INSERT: begin
              if (in_pos == '0) begin
                status_nxt = STS_BADPOS;
              end else if (cnt_r >= CNT_MAX || free_r == NIL) begin
                status_nxt = STS_FULL;
              end else if (pos_x > cnt_x) begin
                status_nxt   = STS_BEYOND;
                prev_nil_nxt = (cnt_r == '0);
                steps_nxt    = cnt_x - XW'(1);
                state_nxt    = S_ALLOC_RD;
              end else begin
                prev_nil_nxt = (pos_x == XW'(1));
                steps_nxt    = pos_x - XW'(2);
                state_nxt    = S_ALLOC_RD;
              end
            end
            ACT_DEL_KEY: begin
              prev_nil_nxt = 1'b1;
              state_nxt    = S_DK_RD;
            end
            ACT_FIND: begin
              state_nxt = S_FD_RD;
            end
            ACT_DEL_POS: begin
              if (in_pos == '0 || pos_x > cnt_x) begin
                status_nxt = STS_BADPOS;
              end else begin
                prev_nil_nxt = (pos_x == XW'(1));
                steps_nxt    = (pos_x == XW'(1)) ? '0 : pos_x - XW'(2);
                state_nxt    = S_WALK;
              end
            end
            ACT_READ: begin
              if (in_pos == '0 || pos_x > cnt_x) begin
                status_nxt = STS_NOTFOUND;
              end else begin
                steps_nxt = pos_x - XW'(1);
                state_nxt = S_WALK;
              end
            end
            default: begin
              status_nxt = STS_BADPOS;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        l_raddr   = free_r[AW-1:0];
        state_nxt = S_ALLOC_GET;
      end
      S_ALLOC_GET: begin
        d_we     = 1'b1;
        d_waddr  = free_r[AW-1:0];
        slot_nxt = free_r;
        free_nxt = l_rdata;
        if (prev_nil_r) begin
          state_nxt = S_LINK_RD;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (steps_r == '0) begin
          case (act_r)
            ACT_DEL_POS: state_nxt = S_DP_RD;
            ACT_READ:    state_nxt = S_RD_RD;
            default:     state_nxt = S_LINK_RD;
          endcase
        end else begin
          state_nxt = S_WALK_GET;
        end
      end
      S_WALK_GET: begin
        cur_nxt   = l_rdata;
        steps_nxt = steps_r - XW'(1);
        state_nxt = S_WALK;
      end
      S_LINK_RD: begin
        if (prev_nil_r) begin
          link_nxt  = head_r;
          state_nxt = S_INS_W1;
        end else begin
          state_nxt = S_LINK_GET;
        end
      end
      S_LINK_GET: begin
        link_nxt  = l_rdata;
        state_nxt = S_INS_W1;
      end
      S_INS_W1: begin
        l_we    = 1'b1;
        l_waddr = slot_r[AW-1:0];
        l_wdata = link_r;
        cnt_nxt = cnt_r + CW'(1);
        if (prev_nil_r) begin
          head_nxt  = slot_r;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_INS_W2;
        end
      end
      S_INS_W2: begin
        l_we      = 1'b1;
        state_nxt = S_RESULT;
      end
      S_DP_RD: begin
        if (prev_nil_r) begin
          slot_nxt  = head_r;
          state_nxt = S_DP_NXT_RD;
        end else begin
          state_nxt = S_DP_GET;
        end
      end
      S_DP_GET: begin
        slot_nxt  = l_rdata;
        state_nxt = S_DP_NXT_RD;
      end
      S_DP_NXT_RD: begin
        l_raddr   = slot_r[AW-1:0];
        state_nxt = S_DP_NXT_GET;
      end
      S_DP_NXT_GET: begin
        link_nxt  = l_rdata;
        state_nxt = S_DP_W1;
      end
      S_DP_W1: begin
        if (prev_nil_r) begin
          head_nxt = link_r;
        end else begin
          l_we    = 1'b1;
          l_wdata = link_r;
        end
        state_nxt = S_DP_W2;
      end
      S_DP_W2: begin
        l_we      = 1'b1;
        l_waddr   = slot_r[AW-1:0];
        l_wdata   = free_r;
        free_nxt  = slot_r;
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_RESULT;
      end
      S_RD_RD: begin
        state_nxt = S_RD_GET;
      end
      S_RD_GET: begin
        if (cur_r < NIL) begin
          fkey_nxt    = d_rdata[KEY_W-1:0];
          fhandle_nxt = d_rdata[DW-1:KEY_W];
        end
        state_nxt = S_RESULT;
      end
      S_FD_RD: begin
        if (cur_r >= NIL) begin
          status_nxt = STS_NOTFOUND;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_FD_GET;
        end
      end
      S_FD_GET: begin
        if (d_rdata[KEY_W-1:0] == key_r) begin
          fkey_nxt    = d_rdata[KEY_W-1:0];
          fhandle_nxt = d_rdata[DW-1:KEY_W];
          status_nxt  = STS_DONE;
          state_nxt   = S_RESULT;
        end else begin
          cur_nxt   = l_rdata;
          state_nxt = S_FD_RD;
        end
      end
      S_DK_RD: begin
        if (cur_r >= NIL) begin
          status_nxt = hit_r ? STS_DONE : STS_NOTFOUND;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_DK_GET;
        end
      end
      S_DK_GET: begin
        link_nxt = l_rdata;
        if (d_rdata[KEY_W-1:0] == key_r) begin
          state_nxt = S_DK_W1;
        end else begin
          prev_nxt     = cur_r;
          prev_nil_nxt = 1'b0;
          cur_nxt      = l_rdata;
          state_nxt    = S_DK_RD;
        end
      end
      S_DK_W1: begin
        if (prev_nil_r) begin
          head_nxt = link_r;
        end else begin
          l_we    = 1'b1;
          l_waddr = prev_r[AW-1:0];
          l_wdata = link_r;
        end
        state_nxt = S_DK_W2;
      end
      S_DK_W2: begin
        l_we     = 1'b1;
        l_wdata  = free_r;
        free_nxt = cur_r;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CW'(1);
        end
        hit_nxt   = 1'b1;
        cur_nxt   = link_r;
        state_nxt = S_DK_RD;
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_key_nxt    = fkey_r;
          out_handle_nxt = fhandle_r;
          out_len_nxt    = LEN_W'(cnt_r);
          out_empty_nxt  = (cnt_r == '0);
          out_full_nxt   = (cnt_r >= CNT_MAX);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'd0, out_full_r, out_empty_r, out_len_r, out_handle_r, out_key_r};

endmodule

// File: rtl/core/arll_ram.sv
// ----------------------------------------------------------------------------
// arll_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module arll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Array linked list manager testbench
// Drives list requests (append, delete by key, find, insert, delete at
// position, read) into the stream input with random gaps, mirrors the list
// in a behavioral model and compares every result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import arll_pkg::*;

  localparam int NSLOT = DEF_CAPACITY;
  localparam logic [ACTION_W-1:0] ACT_BAD6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_BAD7 = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    fkey;
    logic [HANDLE_W-1:0] fhandle;
    logic [LEN_W-1:0]    length;
    logic                empty;
    logic                full;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ACTION_W-1:0] in_tuser = '0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [STATUS_W-1:0] out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [KEY_W-1:0] list_keys[$];
  logic [HANDLE_W-1:0] list_handles[$];
  list_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  int hold_reqs = 0;
  int hold_seen = 0;

  array_linked_list_manager u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic list_result_t apply_request(logic [ACTION_W-1:0] act,
      logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] hnd, logic [POS_W-1:0] pos);
    list_result_t r;
    int n;
    bit hit;
    r = '0;
    r.status = STS_DONE;
    n = list_keys.size();
    case (act)
      ACT_APPEND: begin
        if (n >= NSLOT) r.status = STS_FULL;
        else begin
          list_keys.push_back(key);
          list_handles.push_back(hnd);
        end
      end
      ACT_DEL_KEY: begin
        hit = 1'b0;
        for (int i = n - 1; i >= 0; i--) begin
          if (list_keys[i] == key) begin
            list_keys.delete(i);
            list_handles.delete(i);
            hit = 1'b1;
          end
        end
        if (!hit) r.status = STS_NOTFOUND;
      end
      ACT_FIND: begin
        r.status = STS_NOTFOUND;
        for (int i = 0; i < n; i++) begin
          if (list_keys[i] == key) begin
            r.status = STS_DONE;
            r.fkey = list_keys[i];
            r.fhandle = list_handles[i];
            break;
          end
        end
      end
      ACT_INSERT: begin
        if (pos == 0) r.status = STS_BADPOS;
        else if (n >= NSLOT) r.status = STS_FULL;
        else if (pos > n) begin
          list_keys.push_back(key);
          list_handles.push_back(hnd);
          r.status = STS_BEYOND;
        end else begin
          list_keys.insert(pos - 1, key);
          list_handles.insert(pos - 1, hnd);
        end
      end
      ACT_DEL_POS: begin
        if (pos == 0 || pos > n) r.status = STS_BADPOS;
        else begin
          list_keys.delete(pos - 1);
          list_handles.delete(pos - 1);
        end
      end
      ACT_READ: begin
        if (pos == 0 || pos > n) r.status = STS_NOTFOUND;
        else begin
          r.fkey = list_keys[pos - 1];
          r.fhandle = list_handles[pos - 1];
        end
      end
      default: r.status = STS_BADPOS;
    endcase
    n = list_keys.size();
    r.length = n[LEN_W-1:0];
    r.empty = (n == 0);
    r.full = (n >= NSLOT);
    return r;
  endfunction

  task automatic send_request(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] key,
      logic [HANDLE_W-1:0] hnd, logic [POS_W-1:0] pos);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {pos, hnd, key};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_request(act, key, hnd, pos));
  endtask

  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_off <= 400;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) < 75);
    end
  end

  always @(posedge clk) begin
    list_result_t exp_r;
    list_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.fkey = out_tdata[31:0];
      got.fhandle = out_tdata[63:32];
      got.length = out_tdata[71:64];
      got.empty = out_tdata[72];
      got.full = out_tdata[73];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction %h", $time, got);
      end else begin
        exp_r = pending_results.pop_front();
        if (got.status !== exp_r.status)
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        if (got.fkey !== exp_r.fkey)
          $display("%0t: key expected %h actual %h", $time, exp_r.fkey, got.fkey);
        if (got.fhandle !== exp_r.fhandle)
          $display("%0t: handle expected %h actual %h", $time, exp_r.fhandle, got.fhandle);
        if (got.length !== exp_r.length)
          $display("%0t: length expected %0d actual %0d", $time, exp_r.length, got.length);
        if (got.empty !== exp_r.empty)
          $display("%0t: empty expected %b actual %b", $time, exp_r.empty, got.empty);
        if (got.full !== exp_r.full)
          $display("%0t: full expected %b actual %b", $time, exp_r.full, got.full);
        if (got !== exp_r) errors++;
      end
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    int n;
    n = list_keys.size();
    if (n > 0 && $urandom_range(0, 2) != 0) return list_keys[$urandom_range(0, n - 1)];
    if ($urandom_range(0, 1)) return $urandom_range(0, 15);
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int n;
    n = list_keys.size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return POS_W'($urandom);
      2: return POS_W'(n + 1);
      default: return POS_W'($urandom_range(1, n > 0 ? n : 1));
    endcase
  endfunction

  task automatic test_directed();
    send_request(ACT_READ, 0, 0, 1);
    send_request(ACT_DEL_KEY, 5, 0, 0);
    send_request(ACT_FIND, 5, 0, 0);
    send_request(ACT_DEL_POS, 0, 0, 1);
    send_request(ACT_APPEND, 32'h8000_0000, 32'hFFFF_FFFF, 8'hFF);
    send_request(ACT_APPEND, 32'h7FFF_FFFF, 32'h0000_0000, 0);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 0);
    send_request(ACT_INSERT, 7, 32'hAAAA_5555, 1);
    send_request(ACT_INSERT, 8, 32'h5555_AAAA, 2);
    send_request(ACT_INSERT, 9, 32'hDEAD_BEEF, 8'hFF);
    send_request(ACT_FIND, 32'h7FFF_FFFF, 0, 0);
    send_request(ACT_READ, 0, 0, 0);
    send_request(ACT_READ, 0, 0, 5);
    send_request(ACT_READ, 0, 0, 6);
    send_request(ACT_DEL_POS, 0, 0, 0);
    send_request(ACT_DEL_POS, 0, 0, 9);
    send_request(ACT_BAD6, 1, 1, 1);
    send_request(ACT_BAD7, 1, 1, 1);
    send_request(ACT_APPEND, 7, 1, 0);
    send_request(ACT_DEL_KEY, 7, 0, 0);
    send_request(ACT_DEL_POS, 0, 0, 3);
    send_request(ACT_DEL_POS, 0, 0, 1);
  endtask

  task automatic test_fill_and_drain();
    while (list_keys.size() < NSLOT)
      send_request(ACT_APPEND, $urandom_range(0, 7), $urandom, 0);
    send_request(ACT_APPEND, 1, 1, 0);
    send_request(ACT_INSERT, 1, 1, 1);
    send_request(ACT_INSERT, 1, 1, 0);
    send_request(ACT_READ, 0, 0, POS_W'(NSLOT));
    send_request(ACT_READ, 0, 0, POS_W'(NSLOT + 1));
    send_request(ACT_DEL_POS, 0, 0, POS_W'(NSLOT));
    for (int k = 0; k < 8; k++) send_request(ACT_DEL_KEY, k, 0, 0);
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    for (int i = 0; i < 6; i++) send_request(ACT_APPEND, $urandom, $urandom, 0);
  endtask

  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) send_request(ACT_APPEND, pick_key(), $urandom, POS_W'($urandom));
      else if (r < 40) send_request(ACT_DEL_KEY, pick_key(), $urandom, POS_W'($urandom));
      else if (r < 52) send_request(ACT_FIND, pick_key(), $urandom, POS_W'($urandom));
      else if (r < 70) send_request(ACT_INSERT, pick_key(), $urandom, pick_pos());
      else if (r < 80) send_request(ACT_DEL_POS, $urandom, $urandom, pick_pos());
      else if (r < 97) send_request(ACT_READ, $urandom, $urandom, pick_pos());
      else send_request(ACTION_W'($urandom_range(6, 7)), $urandom, $urandom,
                        POS_W'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_and_drain();
    test_backpressure();
    test_random(850);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
